@@ hdl/sle_pkg.sv @@
// sle_pkg: shared constants and types for the sprite line evaluation block
// depends on nothing; imported by the top level and its checker
package sle_pkg;

	localparam int SLOTS_PER_LINE = 8;
	localparam int TABLE_ENTRIES  = 64;

	// hit count reaches one past the slot count
	localparam int HIT_W  = $clog2(SLOTS_PER_LINE + 2);
	localparam int SEEK_W = $clog2(TABLE_ENTRIES + 1);
	localparam int SLOT_W = 3;
	localparam int IDX_W  = 6;
	localparam int ROW_W  = 4;
	localparam int LINE_W = 8;
	localparam int CFG_IDX_W = 2;

	// signed working width for y, line and their difference
	localparam int YW = LINE_W + 2;

	localparam logic [LINE_W-1:0] Y_TERMINATOR = 8'd208;
	localparam logic [YW-1:0]     Y_WRAP_LIMIT = 10'd240;
	localparam logic [YW-1:0]     Y_WRAP_SPAN  = 10'd256;
	localparam logic [5:0]        H_SHORT      = 6'd8;
	localparam logic [5:0]        H_TALL       = 6'd16;

	typedef enum logic {
		OP_START = 1'b0,
		OP_ENTRY = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPRITE_TALL = 2'd0,
		CFG_SPRITE_ZOOM = 2'd1,
		CFG_LINES_192   = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic [IDX_W-1:0]  sprite_index;
		logic [ROW_W-1:0]  tile_row;
		logic              overflow;
		logic              done_res;
	} result_t;

endpackage

@@ hdl/sprite_line_evaluation_top.sv @@
// sprite_line_evaluation_top: per-scanline sprite evaluation, one y entry per word
// depends on sle_pkg
//
//   channel   handshake            payload
//   in        in_valid/in_ready    op, line, y_byte
//   out       out_valid/out_ready  hit, slot, sprite_index, tile_row, overflow, done_res
//   cfg       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one word per cycle sustained while out_ready stays high; a word passes through the input
// register and then the result register before it appears on out.
// the input register and the result register are a two-entry pipeline: a
// stalled out side fills both before in_ready drops.
// arst_n clears line state, the valid bits and the registers to their defaults
// (lines_192 set). cfg writes are always taken; cfg_ready is tied high.
module sprite_line_evaluation_top
	import sle_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 op,
	input  logic [LINE_W-1:0]    line,
	input  logic [LINE_W-1:0]    y_byte,

	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 hit,
	output logic [SLOT_W-1:0]    slot,
	output logic [IDX_W-1:0]     sprite_index,
	output logic [ROW_W-1:0]     tile_row,
	output logic                 overflow,
	output logic                 done_res,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic                 cfg_data
);

	logic sprite_tall_q, sprite_zoom_q, lines_192_q;

	logic [HIT_W-1:0]  hit_count_q;
	logic [SEEK_W-1:0] seek_q;
	logic              cancelled_q;
	logic [LINE_W-1:0] cur_line_q;

	logic              valid_s1;
	op_t               op_s1;
	logic [LINE_W-1:0] line_s1;
	logic [LINE_W-1:0] y_s1;

	logic    out_valid_q;
	result_t res_q;

	logic advance;

	// next state and result from the word in the input register
	logic              ended_now;
	logic              is_term;
	logic [YW-1:0]     y_inc;
	logic signed [YW-1:0] y_pos;
	logic signed [YW-1:0] diff;
	logic [5:0]        height;
	logic              covers;
	logic [HIT_W-1:0]  hit_inc;
	logic              stores;
	logic [YW-1:0]     row_full;

	logic [HIT_W-1:0]  hit_count_d;
	logic [SEEK_W-1:0] seek_d;
	logic              cancelled_d;
	logic [LINE_W-1:0] cur_line_d;
	result_t           res_d;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sprite_tall_q <= 1'b0;
			sprite_zoom_q <= 1'b0;
			lines_192_q   <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SPRITE_TALL: sprite_tall_q <= cfg_data;
				CFG_SPRITE_ZOOM: sprite_zoom_q <= cfg_data;
				CFG_LINES_192:   lines_192_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		ended_now = cancelled_q || (hit_count_q > HIT_W'(SLOTS_PER_LINE)) ||
			(seek_q >= SEEK_W'(TABLE_ENTRIES));
		is_term   = lines_192_q && (y_s1 == Y_TERMINATOR);

		// y + 1, wrapping to negative near the bottom of the range
		y_inc = {2'b00, y_s1} + YW'(1);
		if (y_inc > Y_WRAP_LIMIT)
			y_pos = signed'(y_inc - Y_WRAP_SPAN);
		else
			y_pos = signed'(y_inc);

		diff   = signed'({2'b00, cur_line_q}) - y_pos;
		height = (sprite_tall_q ? H_TALL : H_SHORT) << sprite_zoom_q;
		covers = !diff[YW-1] && (diff < signed'({{(YW-6){1'b0}}, height}));

		hit_inc  = hit_count_q + HIT_W'(1);
		stores   = hit_inc <= HIT_W'(SLOTS_PER_LINE);
		row_full = unsigned'(diff) >> sprite_zoom_q;

		hit_count_d = hit_count_q;
		seek_d      = seek_q;
		cancelled_d = cancelled_q;
		cur_line_d  = cur_line_q;
		res_d       = '0;

		case (op_s1)
			OP_START: begin
				cur_line_d  = line_s1;
				hit_count_d = '0;
				seek_d      = '0;
				cancelled_d = 1'b0;
			end
			OP_ENTRY: begin
				if (!ended_now) begin
					if (is_term) begin
						cancelled_d = 1'b1;
					end else if (covers) begin
						hit_count_d = hit_inc;
						if (stores) begin
							seek_d             = seek_q + SEEK_W'(1);
							res_d.hit          = 1'b1;
							res_d.slot         = hit_count_q[SLOT_W-1:0];
							res_d.sprite_index = seek_q[IDX_W-1:0];
							res_d.tile_row     = row_full[ROW_W-1:0];
						end
					end else begin
						seek_d = seek_q + SEEK_W'(1);
					end
				end
				res_d.overflow = hit_count_d > HIT_W'(SLOTS_PER_LINE);
				res_d.done_res = cancelled_d || res_d.overflow ||
					(seek_d >= SEEK_W'(TABLE_ENTRIES));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			hit_count_q <= '0;
			seek_q      <= '0;
			cancelled_q <= 1'b0;
			cur_line_q  <= '0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance) begin
				out_valid_q <= 1'b1;
				hit_count_q <= hit_count_d;
				seek_q      <= seek_d;
				cancelled_q <= cancelled_d;
				cur_line_q  <= cur_line_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= op_t'(op);
			line_s1 <= line;
			y_s1    <= y_byte;
		end
		if (advance)
			res_q <= res_d;
	end

	assign out_valid    = out_valid_q;
	assign hit          = res_q.hit;
	assign slot         = res_q.slot;
	assign sprite_index = res_q.sprite_index;
	assign tile_row     = res_q.tile_row;
	assign overflow     = res_q.overflow;
	assign done_res     = res_q.done_res;

endmodule

@@ hdl/sle_checker.sv @@
// sle_checker: port-level checks on the sprite line evaluation top level
// depends on sle_pkg; bound to sprite_line_evaluation_top below
module sle_checker
	import sle_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 op,
	input logic [LINE_W-1:0]    line,
	input logic [LINE_W-1:0]    y_byte,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic                 hit,
	input logic [SLOT_W-1:0]    slot,
	input logic [IDX_W-1:0]     sprite_index,
	input logic [ROW_W-1:0]     tile_row,
	input logic                 overflow,
	input logic                 done_res,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic                 cfg_data
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(slot) &&
			$stable(sprite_index) && $stable(tile_row) && $stable(overflow) &&
			$stable(done_res))
		else $error("result word changed while stalled");

	// a stored sprite never comes with overflow
	a_hit_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> !overflow)
		else $error("hit reported together with overflow");

	a_ovf_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> done_res)
		else $error("overflow without end of evaluation");

	// slot fields are zero unless a sprite was stored
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> slot == '0 && sprite_index == '0 && tile_row == '0)
		else $error("slot fields set on a miss");

endmodule

bind sprite_line_evaluation_top sle_checker u_sle_checker (.*);
